// ----- sv/pnf_pkg.sv -----
package pnf_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = 8;
  localparam int FRAC_DEF    = 16;
  localparam int MAX_OCT_DEF = 8;
  localparam int OCT_W       = 4;
  localparam int CFG_W       = 4;
  localparam int OFF_W       = 18;
  localparam int GRAD_W      = 19;
  localparam int LV_W        = 20;
  localparam int MA_W        = 24;
  localparam int MB_W        = 17;
  localparam int MP_W        = MA_W + MB_W + 1;
  localparam int P_W         = 36;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic CFG_PLAIN  = 1'b0;
  localparam logic CFG_OCTAVE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OCT,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_R4,
    ST_R5,
    ST_R6,
    ST_L0,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_FIN
  } state_t;

  // 8-way hash gradient on Q.16 offsets
  function automatic logic signed [GRAD_W-1:0] grad(
    input logic [2:0]              h,
    input logic signed [OFF_W-1:0] x,
    input logic signed [OFF_W-1:0] y
  );
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    logic signed [GRAD_W-1:0] su;
    logic signed [GRAD_W-1:0] sv;
    u  = h[2] ? GRAD_W'(y) : GRAD_W'(x);
    v  = h[2] ? GRAD_W'(x) : GRAD_W'(y);
    su = h[0] ? -u : u;
    sv = h[1] ? -v : v;
    return su + sv;
  endfunction

endpackage

// ----- sv/perlin_noise_fbm_2d.sv -----
// channel  direction  ports                                         handshake
// in       input      in_cmd in_x_pos in_y_pos in_table_index
//                     in_table_value                                in_valid / in_ready
// out      output     out_noise_value                               out_valid / out_ready
// cfg      input      cfg_index cfg_wdata                           cfg_we (no wait)
//
// A load word writes its table entry at acceptance.
// An evaluate word runs its octaves in turn, and no new word is taken until it is done: each
// fade uses the shared multiplier 7 times, the table port reads six hashes,
// and the three lerps use the multiplier once each.
// rst_n is synchronous, active low; the permutation table is not cleared.
// The result sits in an output register; the next word is taken while it waits,
// and a finished evaluation holds in its last step until that register is free.
module perlin_noise_fbm_2d #(
  parameter int FRAC_BITS   = pnf_pkg::FRAC_DEF,
  parameter int MAX_OCTAVES = pnf_pkg::MAX_OCT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic signed [31:0]          in_x_pos,
  input  logic signed [31:0]          in_y_pos,
  input  logic [7:0]                  in_table_index,
  input  logic [7:0]                  in_table_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_noise_value,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pnf_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int ACC_W = MAX_OCTAVES + 22;
  localparam int FSH   = 32 - FRAC_BITS;
  localparam logic [pnf_pkg::OCT_W-1:0] MAX_N = pnf_pkg::OCT_W'(MAX_OCTAVES);

  pnf_pkg::state_t state_r, state_nxt;

  // configuration
  logic                       plain_r;
  logic [pnf_pkg::CFG_W-1:0]  oct_cfg_r;

  // coordinate and octave bookkeeping
  logic [31:0]                xs_r, ys_r;
  logic [15:0]                xf_r, yf_r;
  logic [7:0]                 xi_r, yi_r;
  logic [pnf_pkg::OCT_W-1:0]  oct_idx_r, oct_n_r;

  // fade loop
  logic                       sel_r;
  logic [1:0]                 iter_r;
  logic [pnf_pkg::P_W-1:0]    p_r, tmp_r;
  logic [16:0]                u_r, v_r;

  // hashes and lerps
  logic [7:0]                 pa_r, pb_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [pnf_pkg::LV_W-1:0] l1_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_valid_r;
  logic signed [15:0]         out_noise_r;

  // shared multiplier and table port
  logic signed [pnf_pkg::MA_W-1:0] mul_a;
  logic [pnf_pkg::MB_W-1:0]        mul_b;
  logic signed [pnf_pkg::MP_W-1:0] mul_r;
  logic [7:0]                      raddr;
  logic [7:0]                      rdata;
  logic                            tbl_we;

  logic in_acc;
  logic fin_go;

  assign in_acc = in_valid && in_ready;
  assign tbl_we = in_acc && (in_cmd == pnf_pkg::CMD_LOAD);
  assign fin_go = (state_r == pnf_pkg::ST_FIN) && (!out_valid_r || out_ready);

  pnf_ram #(
    .WIDTH (8),
    .DEPTH (pnf_pkg::TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_table_index),
    .wdata (in_table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  pnf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_r)
  );

  // split the current octave's coordinates into lattice cell and Q0.16 offset
  logic [31:0] xsh, ysh, xint, yint;
  assign xsh  = xs_r << FSH;
  assign ysh  = ys_r << FSH;
  assign xint = xs_r >> FRAC_BITS;
  assign yint = ys_r >> FRAC_BITS;

  logic [15:0] fade_t;
  assign fade_t = sel_r ? yf_r : xf_r;

  // fade seed: 6t^2 - 15t*2^16 + 10*2^32, always non-negative
  logic [39:0] m40, t40, p0;
  assign m40 = {7'b0, mul_r[32:0]};
  assign t40 = {24'b0, fade_t};
  assign p0  = (m40 << 2) + (m40 << 1) - (((t40 << 4) - t40) << 16) + (40'd10 << 32);

  // one fade iteration: floor(p*t / 2^16) from high and low halves of p
  logic [pnf_pkg::P_W-1:0] pnew;
  assign pnew = tmp_r + {20'b0, mul_r[31:16]};

  // corner offsets and gradients
  logic signed [pnf_pkg::OFF_W-1:0] xo_s, yo_s, x1_s, y1_s;
  assign xo_s = $signed({2'b0, xf_r});
  assign yo_s = $signed({2'b0, yf_r});
  assign x1_s = xo_s - $signed(pnf_pkg::OFF_W'(65536));
  assign y1_s = yo_s - $signed(pnf_pkg::OFF_W'(65536));

  logic signed [pnf_pkg::GRAD_W-1:0] g_aa, g_ba, g_ab, g_bb;
  assign g_aa = pnf_pkg::grad(aa_r[2:0], xo_s, yo_s);
  assign g_ba = pnf_pkg::grad(ba_r[2:0], x1_s, yo_s);
  assign g_ab = pnf_pkg::grad(ab_r[2:0], xo_s, y1_s);
  assign g_bb = pnf_pkg::grad(bb_r[2:0], x1_s, y1_s);

  // floor(product / 2^16); lerp results fit, so keep the low bits
  logic signed [pnf_pkg::MP_W-1:0] mul_sh;
  logic signed [pnf_pkg::LV_W-1:0] mul_lo, l1_new, l2_new, noise_new;
  assign mul_sh    = mul_r >>> 16;
  assign mul_lo    = mul_sh[pnf_pkg::LV_W-1:0];
  assign l1_new    = pnf_pkg::LV_W'(g_aa) + mul_lo;
  assign l2_new    = pnf_pkg::LV_W'(g_ab) + mul_lo;
  assign noise_new = l1_r + mul_lo;

  // octave weight 2^(MAX_OCTAVES-1-i); plain mode adds the noise unweighted
  logic [pnf_pkg::OCT_W-1:0] wsh;
  logic signed [ACC_W-1:0]   term;
  assign wsh  = plain_r ? '0 : (MAX_N - pnf_pkg::OCT_W'(1) - oct_idx_r);
  assign term = ACC_W'(noise_new) <<< wsh;

  // round half up to Q2.14 and saturate
  logic signed [ACC_W-1:0] rnd, r_full;
  logic signed [15:0]      sat;
  assign rnd    = plain_r ? ACC_W'(2) : (ACC_W'(1) <<< (MAX_OCTAVES + 1));
  assign r_full = plain_r ? ((acc_r + rnd) >>> 2) : ((acc_r + rnd) >>> (MAX_OCTAVES + 2));

  always_comb begin
    if (r_full > $signed(ACC_W'(32767))) begin
      sat = 16'sh7fff;
    end else if (r_full < -$signed(ACC_W'(32768))) begin
      sat = -16'sh8000;
    end else begin
      sat = r_full[15:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pnf_pkg::ST_IDLE: begin
        if (in_valid && in_cmd == pnf_pkg::CMD_EVAL) begin
          state_nxt = pnf_pkg::ST_OCT;
        end
      end
      pnf_pkg::ST_OCT: begin
        state_nxt = (oct_idx_r == oct_n_r) ? pnf_pkg::ST_FIN : pnf_pkg::ST_F0;
      end
      pnf_pkg::ST_F0: state_nxt = pnf_pkg::ST_F1;
      pnf_pkg::ST_F1: state_nxt = pnf_pkg::ST_F2;
      pnf_pkg::ST_F2: state_nxt = pnf_pkg::ST_F3;
      pnf_pkg::ST_F3: state_nxt = pnf_pkg::ST_F4;
      pnf_pkg::ST_F4: begin
        if (iter_r != 2'd2) begin
          state_nxt = pnf_pkg::ST_F2;
        end else begin
          state_nxt = sel_r ? pnf_pkg::ST_R0 : pnf_pkg::ST_F0;
        end
      end
      pnf_pkg::ST_R0: state_nxt = pnf_pkg::ST_R1;
      pnf_pkg::ST_R1: state_nxt = pnf_pkg::ST_R2;
      pnf_pkg::ST_R2: state_nxt = pnf_pkg::ST_R3;
      pnf_pkg::ST_R3: state_nxt = pnf_pkg::ST_R4;
      pnf_pkg::ST_R4: state_nxt = pnf_pkg::ST_R5;
      pnf_pkg::ST_R5: state_nxt = pnf_pkg::ST_R6;
      pnf_pkg::ST_R6: state_nxt = pnf_pkg::ST_L0;
      pnf_pkg::ST_L0: state_nxt = pnf_pkg::ST_L1;
      pnf_pkg::ST_L1: state_nxt = pnf_pkg::ST_L2;
      pnf_pkg::ST_L2: state_nxt = pnf_pkg::ST_L3;
      pnf_pkg::ST_L3: state_nxt = pnf_pkg::ST_OCT;
      pnf_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = pnf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pnf_pkg::ST_IDLE;
    endcase
  end

  // multiplier operands and table address per step
  always_comb begin
    in_ready = (state_r == pnf_pkg::ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    raddr    = '0;
    case (state_r)
      pnf_pkg::ST_F0: begin
        mul_a = pnf_pkg::MA_W'({1'b0, fade_t});
        mul_b = pnf_pkg::MB_W'(fade_t);
      end
      pnf_pkg::ST_F2: begin
        mul_a = pnf_pkg::MA_W'({1'b0, p_r[35:16]});
        mul_b = pnf_pkg::MB_W'(fade_t);
      end
      pnf_pkg::ST_F3: begin
        mul_a = pnf_pkg::MA_W'({1'b0, p_r[15:0]});
        mul_b = pnf_pkg::MB_W'(fade_t);
      end
      pnf_pkg::ST_R0: raddr = xi_r;
      pnf_pkg::ST_R1: raddr = xi_r + 8'd1;
      pnf_pkg::ST_R2: raddr = pa_r + yi_r;
      pnf_pkg::ST_R3: raddr = pa_r + yi_r + 8'd1;
      pnf_pkg::ST_R4: raddr = pb_r + yi_r;
      pnf_pkg::ST_R5: raddr = pb_r + yi_r + 8'd1;
      pnf_pkg::ST_L0: begin
        mul_a = pnf_pkg::MA_W'(pnf_pkg::LV_W'(g_ba) - pnf_pkg::LV_W'(g_aa));
        mul_b = u_r;
      end
      pnf_pkg::ST_L1: begin
        mul_a = pnf_pkg::MA_W'(pnf_pkg::LV_W'(g_bb) - pnf_pkg::LV_W'(g_ab));
        mul_b = u_r;
      end
      pnf_pkg::ST_L2: begin
        mul_a = pnf_pkg::MA_W'(l2_new - l1_r);
        mul_b = v_r;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pnf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      plain_r     <= 1'b0;
      oct_cfg_r   <= pnf_pkg::CFG_W'(2);
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pnf_pkg::CFG_PLAIN:  plain_r   <= cfg_wdata[0];
          pnf_pkg::CFG_OCTAVE: oct_cfg_r <= cfg_wdata;
          default:             plain_r   <= plain_r;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      pnf_pkg::ST_IDLE: begin
        if (in_acc && in_cmd == pnf_pkg::CMD_EVAL) begin
          xs_r      <= in_x_pos;
          ys_r      <= in_y_pos;
          acc_r     <= '0;
          oct_idx_r <= '0;
          if (plain_r) begin
            oct_n_r <= pnf_pkg::OCT_W'(1);
          end else if (oct_cfg_r > MAX_N) begin
            oct_n_r <= MAX_N;
          end else begin
            oct_n_r <= oct_cfg_r;
          end
        end
      end
      pnf_pkg::ST_OCT: begin
        xf_r  <= xsh[31:16];
        yf_r  <= ysh[31:16];
        xi_r  <= xint[7:0];
        yi_r  <= yint[7:0];
        sel_r <= 1'b0;
      end
      pnf_pkg::ST_F1: begin
        p_r    <= p0[pnf_pkg::P_W-1:0];
        iter_r <= 2'd0;
      end
      pnf_pkg::ST_F3: begin
        tmp_r <= mul_r[pnf_pkg::P_W-1:0];
      end
      pnf_pkg::ST_F4: begin
        p_r    <= pnew;
        iter_r <= iter_r + 2'd1;
        if (iter_r == 2'd2) begin
          if (sel_r) begin
            v_r <= pnew[32:16];
          end else begin
            u_r   <= pnew[32:16];
            sel_r <= 1'b1;
          end
        end
      end
      pnf_pkg::ST_R1: pa_r <= rdata;
      pnf_pkg::ST_R2: pb_r <= rdata;
      pnf_pkg::ST_R3: aa_r <= rdata;
      pnf_pkg::ST_R4: ab_r <= rdata;
      pnf_pkg::ST_R5: ba_r <= rdata;
      pnf_pkg::ST_R6: bb_r <= rdata;
      pnf_pkg::ST_L1: l1_r <= l1_new;
      pnf_pkg::ST_L3: begin
        // advance to the next octave at twice the frequency
        acc_r     <= acc_r + term;
        oct_idx_r <= oct_idx_r + pnf_pkg::OCT_W'(1);
        xs_r      <= xs_r << 1;
        ys_r      <= ys_r << 1;
      end
      pnf_pkg::ST_FIN: begin
        if (fin_go) begin
          out_noise_r <= sat;
        end
      end
      default: begin
        tmp_r <= tmp_r;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

endmodule

// ----- sv/pnf_ram.sv -----
module pnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pnf_mul.sv -----
// signed by unsigned multiply, product registered
module pnf_mul (
  input  logic                            clk,
  input  logic signed [pnf_pkg::MA_W-1:0] a,
  input  logic [pnf_pkg::MB_W-1:0]        b,
  output logic signed [pnf_pkg::MP_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= pnf_pkg::MP_W'(a * $signed({1'b0, b}));
  end

endmodule

// ----- test/noise_checker.sv -----
`timescale 1ns / 1ps

module noise_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_cmd,
  input  logic signed [31:0] in_x_pos,
  input  logic signed [31:0] in_y_pos,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_noise_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [pnf_pkg::CFG_W-1:0] cfg_wdata,
  output int                 errors,
  output int                 pending
);

  localparam int OCT_LIMIT = 8;

  logic [7:0]                perm_copy [pnf_pkg::TABLE_SIZE];
  logic                      plain_sel;
  logic [pnf_pkg::OCT_W-1:0] octaves;
  logic signed [15:0]        noise_due [$];

  function automatic longint fade_curve(longint t);
    longint p;
    p = 6 * t * t - 15 * t * 65536 + 10 * 64'sd4294967296;
    repeat (3) p = (p * t) >>> 16;
    return p >>> 16;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint hash_grad(logic [7:0] h, longint x, longint y);
    longint u;
    longint v;
    u = h[2] ? y : x;
    v = h[2] ? x : y;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint lattice_noise(logic [31:0] xc, logic [31:0] yc);
    logic [7:0] xi;
    logic [7:0] yi;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] aa;
    logic [7:0] ab;
    logic [7:0] ba;
    logic [7:0] bb;
    longint xf;
    longint yf;
    longint u;
    longint v;
    xi = xc[23:16];
    yi = yc[23:16];
    xf = longint'(xc[15:0]);
    yf = longint'(yc[15:0]);
    u  = fade_curve(xf);
    v  = fade_curve(yf);
    pa = perm_copy[xi];
    pb = perm_copy[8'(xi + 8'd1)];
    aa = perm_copy[8'(pa + yi)];
    ab = perm_copy[8'(pa + yi + 8'd1)];
    ba = perm_copy[8'(pb + yi)];
    bb = perm_copy[8'(pb + yi + 8'd1)];
    return blend(blend(hash_grad(aa, xf, yf), hash_grad(ba, xf - 65536, yf), u),
                 blend(hash_grad(ab, xf, yf - 65536),
                       hash_grad(bb, xf - 65536, yf - 65536), u), v);
  endfunction

  function automatic logic signed [15:0] fbm_sample(logic [31:0] xc, logic [31:0] yc);
    longint acc;
    longint r;
    int     n;
    int     k;
    acc = 0;
    if (plain_sel) begin
      acc = lattice_noise(xc, yc);
      k   = 2;
    end else begin
      n = (octaves > OCT_LIMIT) ? OCT_LIMIT : int'(octaves);
      for (int i = 0; i < n; i++)
        acc += lattice_noise(xc << i, yc << i) <<< (OCT_LIMIT - 1 - i);
      k = OCT_LIMIT + 2;
    end
    r = (acc + (64'sd1 <<< (k - 1))) >>> k;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      plain_sel = 1'b0;
      octaves   = 4'd2;
      noise_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == pnf_pkg::CFG_PLAIN) plain_sel = cfg_wdata[0];
        else octaves = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        if (in_cmd == pnf_pkg::CMD_LOAD) perm_copy[in_table_index] = in_table_value;
        else noise_due.push_back(fbm_sample(in_x_pos, in_y_pos));
      end
      if (out_valid && out_ready) begin
        if (noise_due.size() == 0) begin
          $error("noise_value: unexpected word %0d", out_noise_value);
          errors++;
        end else begin
          logic signed [15:0] want;
          want = noise_due.pop_front();
          if (want !== out_noise_value) begin
            $error("noise_value: expected %0d, got %0d", want, out_noise_value);
            errors++;
          end
        end
      end
    end
    pending = noise_due.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_cmd;
  logic signed [31:0] in_x_pos;
  logic signed [31:0] in_y_pos;
  logic [7:0]         in_table_index;
  logic [7:0]         in_table_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_noise_value;
  logic               cfg_we;
  logic               cfg_index;
  logic [pnf_pkg::CFG_W-1:0] cfg_wdata;
  int                 errors;
  int                 pending;
  int                 burst_left;
  bit                 hold_off_req;
  longint             cycles;

  perlin_noise_fbm_2d dut (.*);

  noise_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: segments of steady, sparse and dense stalls, plus one long
  // hold-off so the engine backs up and drops in_ready.
  initial begin
    int  seg;
    int  dens;
    bit  held;
    held      = 0;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req && !held) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (4000) @(posedge clk);
      end
      seg  = $urandom_range(1, 200);
      dens = $urandom_range(0, 3);
      repeat (seg) begin
        case (dens)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one word; hold valid through bursts, drop it only for a gap.
  task automatic send_word(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                           input logic [7:0] idx, input logic [7:0] val);
    bit took;
    int gap;
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_x_pos       <= x;
    in_y_pos       <= y;
    in_table_index <= idx;
    in_table_value <= val;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic eval_at(input logic [31:0] x, input logic [31:0] y);
    send_word(pnf_pkg::CMD_EVAL, x, y, 8'($urandom), 8'($urandom));
  endtask

  // Drain: wait out every due result, then let a trailing load finish.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_mode(input logic plain, input logic [pnf_pkg::CFG_W-1:0] oct);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= pnf_pkg::CFG_PLAIN;
    cfg_wdata <= pnf_pkg::CFG_W'(plain);
    @(posedge clk);
    cfg_index <= pnf_pkg::CFG_OCTAVE;
    cfg_wdata <= oct;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly evaluations with random coordinates; some table rewrites.
  task automatic random_run(input int count);
    logic [31:0] x;
    logic [31:0] y;
    repeat (count) begin
      x = $urandom;
      y = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        x = {16'($urandom_range(0, 3)), x[15:0]};
        y = {16'($urandom_range(0, 3)), y[15:0]};
      end
      if ($urandom_range(0, 4) == 0)
        send_word(pnf_pkg::CMD_LOAD, x, y, 8'($urandom), 8'($urandom));
      else
        eval_at(x, y);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = pnf_pkg::CMD_LOAD;
    in_x_pos       = '0;
    in_y_pos       = '0;
    in_table_index = '0;
    in_table_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = pnf_pkg::CFG_PLAIN;
    cfg_wdata      = '0;
    hold_off_req   = 0;
    burst_left     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table first so no evaluation reads an unwritten entry.
    for (int i = 0; i < pnf_pkg::TABLE_SIZE; i++)
      send_word(pnf_pkg::CMD_LOAD, $urandom, $urandom, 8'(i), 8'(i * 167 + 13));

    // Directed corners at reset settings: origin, extremes, wrap, fraction ends.
    eval_at(32'h0000_0000, 32'h0000_0000);
    eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_at(32'h8000_0000, 32'h8000_0000);
    eval_at(32'hFFFF_FFFF, 32'h0000_0000);
    eval_at(32'h0000_FFFF, 32'hFFFF_0000);
    eval_at(32'h00FF_8000, 32'h0000_8000);
    send_word(pnf_pkg::CMD_LOAD, '0, '0, 8'hFF, 8'hFF);
    send_word(pnf_pkg::CMD_LOAD, '0, '0, 8'h00, 8'h00);
    eval_at(32'h00FF_4000, 32'h00FF_C000);
    eval_at(32'h0001_0000, 32'hFFFF_8000);

    set_mode(1'b1, 4'd2);
    eval_at(32'h0000_0000, 32'h0000_0000);
    eval_at(32'h7FFF_FFFF, 32'h8000_0000);
    eval_at(32'h0080_8000, 32'h0040_2000);

    set_mode(1'b0, 4'd0);
    eval_at(32'h1234_5678, 32'h9ABC_DEF0);
    set_mode(1'b0, 4'd15);
    eval_at(32'h1234_5678, 32'h9ABC_DEF0);

    // Random phases across settings, extremes included.
    set_mode(1'b0, 4'd2);
    random_run(60);
    set_mode(1'b1, 4'd8);
    hold_off_req = 1;
    random_run(80);
    set_mode(1'b0, 4'd1);
    random_run(60);
    set_mode(1'b0, 4'd8);
    random_run(40);
    set_mode(1'b0, 4'd0);
    random_run(30);
    set_mode(1'b0, 4'd12);
    random_run(30);
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(1'($urandom), 4'($urandom_range(1, 4)));
      random_run(30);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pnf_pkg.sv
sv/pnf_ram.sv
sv/pnf_mul.sv
sv/perlin_noise_fbm_2d.sv
test/noise_checker.sv
test/testbench.sv
